FILE: sv/sdg_pkg.sv
// Shared types, constants and helpers of the square duty generator.
package sdg_pkg;

   localparam int unsigned TONE_W    = 12;
   localparam int unsigned TICKS_W   = 12;
   localparam int unsigned COUNT_W   = 14;
   localparam int unsigned WTICKS_W  = 21;
   localparam int unsigned WSUM_W    = 22;
   localparam int unsigned LEVEL_W   = 16;
   localparam int unsigned DIV_NUM_W = 36;
   localparam int unsigned DIV_DEN_W = 22;
   localparam int unsigned DIV_Q_W   = 16;

   localparam logic [TICKS_W-1:0]  TICKS_MAX  = 12'd4095;
   localparam logic [WTICKS_W-1:0] WINDOW_MAX = 21'd1048575;

   localparam logic signed [LEVEL_W-1:0] LEVEL_HIGH = 16'sd16384;
   localparam logic signed [LEVEL_W-1:0] LEVEL_LOW  = -16'sd16384;
   localparam logic signed [LEVEL_W-1:0] LEVEL_ZERO = 16'sd0;

   // bit s of a pattern is the level at step s
   localparam logic [7:0] DUTY_PATTERNS [4] = '{8'h80, 8'h81, 8'hE1, 8'h7E};

   typedef enum logic [1:0] {
      KIND_ADVANCE = 2'd0,
      KIND_TRIGGER = 2'd1,
      KIND_SAMPLE  = 2'd2,
      KIND_UNUSED  = 2'd3
   } sdg_kind_type;

   typedef enum logic [1:0] {
      CSR_TONE_FREQUENCY = 2'd0,
      CSR_DUTY_MODE      = 2'd1,
      CSR_SYNTHESIS_MODE = 2'd2
   } sdg_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INTERP,
      ST_DIV,
      ST_OUT
   } sdg_state_type;

   typedef struct packed {
      logic capture;
      logic trigger;
      logic naive_sub;
      logic div_naive;
      logic naive_finish;
      logic interp_open;
      logic interp_step;
      logic sample_naive;
      logic sample_direct;
      logic div_sample;
      logic sample_finish;
      logic load_out;
   } sdg_cmd_type;

   typedef struct packed {
      sdg_kind_type kind;
      logic         naive_mode;
      logic         halted;
      logic         cd_gt_ticks;
      logic         cd_gt_rem;
      logic         changed;
      logic         nyquist;
      logic         win_empty;
      logic         div_overflow;
      logic         div_done;
   } sdg_status_type;

   function automatic logic duty_level(input logic [1:0] duty, input logic [2:0] step);
      logic [7:0] pattern;
      pattern = DUTY_PATTERNS[duty];
      return pattern[step];
   endfunction

endpackage

FILE: sv/sdg_channels.sv
// Request and response channel interfaces of the square duty generator.
interface sdg_req_if;
   import sdg_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   logic [TICKS_W-1:0]   ticks;

   modport source (output valid, output kind, output ticks, input ready);
   modport sink (input valid, input kind, input ticks, output ready);
endinterface

interface sdg_rsp_if;
   import sdg_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [LEVEL_W-1:0] sample_level;

   modport source (output valid, output sample_level, input ready);
   modport sink (input valid, input sample_level, output ready);
endinterface

FILE: sv/sdg_divider.sv
// Restoring divider, one quotient bit per cycle, sixteen quotient bits.
module sdg_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sdg_pkg::DIV_NUM_W-1:0]   numerator,
   input  logic [sdg_pkg::DIV_DEN_W-1:0]   denominator,
   output logic                            done,
   output logic [sdg_pkg::DIV_Q_W-1:0]     quotient,
   output logic [sdg_pkg::DIV_DEN_W-1:0]   remainder
);
   import sdg_pkg::*;

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_Q_W-1:0]   low_ff, low_in;
   logic [3:0]           count_ff, count_in;
   logic                 running_ff, running_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;

   // caller guarantees numerator >> 16 < denominator
   always_comb begin
      rem_in     = rem_ff;
      den_in     = den_ff;
      low_in     = low_ff;
      count_in   = count_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      trial      = {rem_ff, low_ff[DIV_Q_W-1]};
      diff       = trial - {1'b0, den_ff};
      if (start) begin
         rem_in     = {{(DIV_DEN_W-(DIV_NUM_W-DIV_Q_W)){1'b0}}, numerator[DIV_NUM_W-1:DIV_Q_W]};
         low_in     = numerator[DIV_Q_W-1:0];
         den_in     = denominator;
         count_in   = 4'd15;
         running_in = 1'b1;
      end else if (running_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DIV_DEN_W-1:0];
            low_in = {low_ff[DIV_Q_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            low_in = {low_ff[DIV_Q_W-2:0], 1'b0};
         end
         if (count_ff == 4'd0) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end else begin
            count_in = count_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= 4'd0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
   end

   assign done      = done_ff;
   assign quotient  = low_ff;
   assign remainder = rem_ff;
endmodule

FILE: sv/sdg_datapath.sv
// Datapath: configuration, waveform timer, sample window and result registers.
module sdg_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sdg_pkg::sdg_cmd_type                 cmd,
   output sdg_pkg::sdg_status_type              status,
   input  logic [1:0]                           req_kind,
   input  logic [sdg_pkg::TICKS_W-1:0]          req_ticks,
   input  logic                                 csr_write_enable,
   input  logic [1:0]                           csr_index,
   input  logic [sdg_pkg::TONE_W-1:0]           csr_write_data,
   output logic signed [sdg_pkg::LEVEL_W-1:0]   rsp_sample_level
);
   import sdg_pkg::*;

   logic [TONE_W-1:0]          tone_ff;
   logic [1:0]                 duty_ff;
   logic                       synth_ff;
   sdg_kind_type               kind_ff;
   logic [TICKS_W-1:0]         ticks_ff;
   logic [TICKS_W-1:0]         rem_ff;
   logic [COUNT_W-1:0]         countdown_ff;
   logic [2:0]                 step_ff;
   logic                       changed_ff;
   logic                       nyquist_ff;
   logic [WTICKS_W-1:0]        wticks_ff;
   logic signed [WSUM_W-1:0]   wsum_ff;
   logic signed [LEVEL_W-1:0]  result_ff;
   logic signed [LEVEL_W-1:0]  out_level_ff;

   logic                       halted;
   logic [COUNT_W-1:0]         period;
   logic                       level;
   logic [TICKS_W-1:0]         ticks_in;
   logic [TICKS_W-1:0]         naive_d;
   logic [WTICKS_W:0]          wticks_wide;
   logic [WTICKS_W-1:0]        wticks_in;
   logic [TICKS_W-1:0]         add_mag;
   logic signed [WSUM_W:0]     sum_ext;
   logic signed [WSUM_W:0]     add_ext;
   logic signed [WSUM_W:0]     sum_wide;
   logic signed [WSUM_W-1:0]   sum_in;
   logic signed [WSUM_W-1:0]   sum_neg;
   logic [WTICKS_W-1:0]        mag;
   logic [DIV_NUM_W-1:0]       num_sample;
   logic [DIV_NUM_W+1:0]       ovf_limit;
   logic [DIV_NUM_W-1:0]       div_num;
   logic [DIV_DEN_W-1:0]       div_den;
   logic                       div_done;
   logic [DIV_Q_W-1:0]         div_q;
   logic [DIV_DEN_W-1:0]       div_r;
   logic [DIV_Q_W-1:0]         q_clamped;
   logic signed [LEVEL_W-1:0]  q_signed;
   logic signed [LEVEL_W-1:0]  direct_level;

   // period is (2048 - code) * 4; codes with bit 11 set halt the timer
   assign halted = tone_ff[TONE_W-1];
   assign period = halted ? '0 : {12'd2048 - {1'b0, tone_ff[TONE_W-2:0]}, 2'b00};
   assign level  = duty_level(duty_ff, step_ff);

   assign ticks_in = (req_ticks > TICKS_MAX) ? TICKS_MAX : req_ticks;
   assign naive_d  = ticks_ff - countdown_ff[TICKS_W-1:0];

   assign wticks_wide = {1'b0, wticks_ff} + {{(WTICKS_W+1-TICKS_W){1'b0}}, ticks_ff};
   assign wticks_in   = (wticks_wide > {1'b0, WINDOW_MAX}) ? WINDOW_MAX
                                                           : wticks_wide[WTICKS_W-1:0];

   // in the step-change branch countdown <= rem, so it fits the tick width
   assign add_mag  = status.cd_gt_rem ? rem_ff : countdown_ff[TICKS_W-1:0];
   assign sum_ext  = {wsum_ff[WSUM_W-1], wsum_ff};
   assign add_ext  = {{(WSUM_W+1-TICKS_W){1'b0}}, add_mag};
   assign sum_wide = level ? (sum_ext + add_ext) : (sum_ext - add_ext);
   always_comb begin
      if (sum_wide > $signed({2'b00, WINDOW_MAX}))
         sum_in = $signed({1'b0, WINDOW_MAX});
      else if (sum_wide < -$signed({2'b00, WINDOW_MAX}))
         sum_in = -$signed({1'b0, WINDOW_MAX});
      else
         sum_in = sum_wide[WSUM_W-1:0];
   end

   // rounded average: (mag * 2^15 + ticks) / (2 * ticks)
   assign sum_neg    = -wsum_ff;
   assign mag        = wsum_ff[WSUM_W-1] ? sum_neg[WTICKS_W-1:0] : wsum_ff[WTICKS_W-1:0];
   assign num_sample = {mag, 15'b0} + {{(DIV_NUM_W-WTICKS_W){1'b0}}, wticks_ff};
   assign ovf_limit  = {wticks_ff, 17'b0};

   assign div_num = cmd.div_sample ? num_sample
                                   : {{(DIV_NUM_W-TICKS_W){1'b0}}, naive_d};
   assign div_den = cmd.div_sample ? {wticks_ff, 1'b0}
                                   : {{(DIV_DEN_W-COUNT_W){1'b0}}, period};

   sdg_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_naive | cmd.div_sample),
      .numerator   (div_num),
      .denominator (div_den),
      .done        (div_done),
      .quotient    (div_q),
      .remainder   (div_r)
   );

   assign q_clamped    = (div_q > 16'd16384) ? 16'd16384 : div_q;
   assign q_signed     = wsum_ff[WSUM_W-1] ? (LEVEL_ZERO - $signed(q_clamped))
                                           : $signed(q_clamped);
   assign direct_level = status.win_empty ? LEVEL_ZERO
                       : (wsum_ff[WSUM_W-1] ? LEVEL_LOW : LEVEL_HIGH);

   always_comb begin
      status.kind         = kind_ff;
      status.naive_mode   = ~synth_ff;
      status.halted       = halted;
      status.cd_gt_ticks  = countdown_ff > {{(COUNT_W-TICKS_W){1'b0}}, ticks_ff};
      status.cd_gt_rem    = countdown_ff > {{(COUNT_W-TICKS_W){1'b0}}, rem_ff};
      status.changed      = changed_ff;
      status.nyquist      = nyquist_ff;
      status.win_empty    = (wticks_ff == '0) | nyquist_ff;
      status.div_overflow = {2'b00, num_sample} >= ovf_limit;
      status.div_done     = div_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_ff  <= 12'd2048;
         duty_ff  <= 2'd0;
         synth_ff <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TONE_FREQUENCY: tone_ff  <= csr_write_data;
            CSR_DUTY_MODE:      duty_ff  <= csr_write_data[1:0];
            CSR_SYNTHESIS_MODE: synth_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= '0;
         step_ff      <= 3'd0;
         changed_ff   <= 1'b0;
         nyquist_ff   <= 1'b0;
         wticks_ff    <= '0;
         wsum_ff      <= '0;
      end else begin
         if (cmd.trigger) begin
            step_ff      <= 3'd0;
            countdown_ff <= period;
         end
         if (cmd.naive_sub)
            countdown_ff <= countdown_ff - {{(COUNT_W-TICKS_W){1'b0}}, ticks_ff};
         if (cmd.naive_finish) begin
            step_ff      <= step_ff + div_q[2:0] + 3'd1;
            countdown_ff <= period - div_r[COUNT_W-1:0];
         end
         if (cmd.interp_open)
            wticks_ff <= wticks_in;
         if (cmd.interp_step) begin
            if (status.cd_gt_rem) begin
               countdown_ff <= countdown_ff - {{(COUNT_W-TICKS_W){1'b0}}, rem_ff};
               wsum_ff      <= sum_in;
            end else if (changed_ff) begin
               nyquist_ff <= 1'b1;
            end else begin
               changed_ff   <= 1'b1;
               wsum_ff      <= sum_in;
               step_ff      <= step_ff + 3'd1;
               countdown_ff <= period;
            end
         end
         if (cmd.sample_direct || cmd.sample_finish) begin
            changed_ff <= 1'b0;
            nyquist_ff <= 1'b0;
            wticks_ff  <= '0;
            wsum_ff    <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= sdg_kind_type'(req_kind);
         ticks_ff <= ticks_in;
      end
      if (cmd.interp_open)
         rem_ff <= ticks_ff;
      else if (cmd.interp_step)
         rem_ff <= rem_ff - countdown_ff[TICKS_W-1:0];
      if (cmd.sample_naive)
         result_ff <= level ? LEVEL_HIGH : LEVEL_LOW;
      else if (cmd.sample_direct)
         result_ff <= direct_level;
      else if (cmd.sample_finish)
         result_ff <= q_signed;
      if (cmd.load_out)
         out_level_ff <= result_ff;
   end

   assign rsp_sample_level = out_level_ff;
endmodule

FILE: sv/sdg_controller.sv
// Controller: sequences one transaction at a time and owns the response valid.
module sdg_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  sdg_pkg::sdg_status_type   status,
   output sdg_pkg::sdg_cmd_type      cmd
);
   import sdg_pkg::*;

   sdg_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (status.kind)
               KIND_ADVANCE: begin
                  if (status.halted)
                     state_in = ST_IDLE;
                  else if (status.naive_mode)
                     state_in = status.cd_gt_ticks ? ST_IDLE : ST_DIV;
                  else
                     state_in = status.nyquist ? ST_IDLE : ST_INTERP;
               end
               KIND_SAMPLE: begin
                  if (status.naive_mode || status.win_empty || status.div_overflow)
                     state_in = ST_OUT;
                  else
                     state_in = ST_DIV;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_INTERP: begin
            // the advance ends on a partial step or on a second step change
            if (status.cd_gt_rem || status.changed) state_in = ST_IDLE;
         end
         ST_DIV: begin
            if (status.div_done)
               state_in = (status.kind == KIND_ADVANCE) ? ST_IDLE : ST_OUT;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: cmd.capture = req_valid;
         ST_DISPATCH: begin
            unique case (status.kind)
               KIND_ADVANCE: begin
                  if (!status.halted) begin
                     if (status.naive_mode) begin
                        cmd.naive_sub = status.cd_gt_ticks;
                        cmd.div_naive = ~status.cd_gt_ticks;
                     end else begin
                        cmd.interp_open = ~status.nyquist;
                     end
                  end
               end
               KIND_TRIGGER: cmd.trigger = 1'b1;
               KIND_SAMPLE: begin
                  if (status.naive_mode)
                     cmd.sample_naive = 1'b1;
                  else if (status.win_empty || status.div_overflow)
                     cmd.sample_direct = 1'b1;
                  else
                     cmd.div_sample = 1'b1;
               end
               default: ;
            endcase
         end
         ST_INTERP: cmd.interp_step = 1'b1;
         ST_DIV: begin
            if (status.div_done) begin
               cmd.naive_finish  = (status.kind == KIND_ADVANCE);
               cmd.sample_finish = (status.kind != KIND_ADVANCE);
            end
         end
         ST_OUT: cmd.load_out = out_free;
         default: ;
      endcase
   end

   always_comb begin
      if (cmd.load_out)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

FILE: sv/square_duty_generator.sv
// Top level of the square duty generator: controller, datapath and channels.
//
// Usage:
//   req_channel carries one transaction per item: kind 0 advances the timer by
//   ticks, kind 1 restarts the waveform, kind 2 asks for one sample, kind 3 is
//   dropped. Only kind 2 produces a transaction on rsp_channel (Q2.14 level).
//   csr_* writes tone frequency, duty pattern and naive/averaged mode; write
//   them only while no transaction is in flight.
// Sequencing:
//   req ready is high only in the idle state; one transaction is worked at a
//   time. Restart, halted or short advances return from dispatch to idle;
//   an interpolating advance runs the interpolation state, repeating it when a
//   step change falls inside it. Naive wrapping advances and averaged samples
//   wait on the restoring divider; naive or direct samples skip it.
// Reset:
//   synchronous; timer, step and sample window clear, frequency code 2048
//   (halted), duty pattern 0, averaged mode.
// Backpressure:
//   the response sits in an output register until taken; the next request is
//   accepted meanwhile, and only a later result waits for the register.
module square_duty_generator (
   input  logic                         clock,
   input  logic                         reset,
   sdg_req_if.sink                      req_channel,
   sdg_rsp_if.source                    rsp_channel,
   input  logic                         csr_write_enable,
   input  logic [1:0]                   csr_index,
   input  logic [sdg_pkg::TONE_W-1:0]   csr_write_data
);
   import sdg_pkg::*;

   sdg_cmd_type                 cmd;
   sdg_status_type              status;
   logic                        req_ready;
   logic                        rsp_valid;
   logic signed [LEVEL_W-1:0]   sample_level;

   sdg_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_channel.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdg_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_channel.kind),
      .req_ticks        (req_channel.ticks),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_sample_level (sample_level)
   );

   assign req_channel.ready        = req_ready;
   assign rsp_channel.valid        = rsp_valid;
   assign rsp_channel.sample_level = sample_level;
endmodule

FILE: sv/sdg_checker.sv
// Port-level checker of the square duty generator and its bind.
module sdg_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [sdg_pkg::LEVEL_W-1:0]  rsp_sample_level
);
   import sdg_pkg::*;

   // response transaction holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample_level))
      else $error("response level changed while stalled");

   // one transaction at a time: ready drops right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous transaction in flight");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_level <= LEVEL_HIGH) && (rsp_sample_level >= LEVEL_LOW))
      else $error("response level out of range");
endmodule

bind square_duty_generator sdg_checker u_sdg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_channel.valid),
   .req_ready        (req_channel.ready),
   .rsp_valid        (rsp_channel.valid),
   .rsp_ready        (rsp_channel.ready),
   .rsp_sample_level (rsp_channel.sample_level)
);
